@@ rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg: shared definitions for the linear congruence solver
// Field widths, status codes and the control structs of the shared divider.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int WIDTH = 32;             // width of every numeric field
   localparam int DW    = 2 * WIDTH;      // double-width dividend
   localparam int CNT_W = $clog2(DW + 1); // divider step counter

   typedef enum logic [1:0] {
      STATUS_SOLVED   = 2'd0,
      STATUS_NONE     = 2'd1,
      STATUS_ZERO_MOD = 2'd2
   } status_type;

   // request to the shared divider
   typedef struct packed {
      logic start;   // load operands and begin
      logic wide;    // DW-bit dividend instead of WIDTH-bit
   } div_ctl_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;    // one-cycle pulse, quotient/remainder valid
   } div_sts_type;

endpackage

@@ rtl/lcs_if.sv @@
// ----------------------------------------------------------------------------
// lcs_if: request and response channels
// Valid/ready channels carrying the congruence operands and the solution.
// ----------------------------------------------------------------------------
interface lcs_req_if;
   logic                      valid;
   logic                      ready;
   logic [lcs_pkg::WIDTH-1:0] coefficient;
   logic [lcs_pkg::WIDTH-1:0] target;
   logic [lcs_pkg::WIDTH-1:0] modulus;

   modport source (output valid, output coefficient, output target, output modulus,
                   input ready);
   modport sink   (input valid, input coefficient, input target, input modulus,
                   output ready);
endinterface

interface lcs_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lcs_pkg::WIDTH-1:0] solution;
   logic [lcs_pkg::WIDTH-1:0] common_divisor;
   logic [lcs_pkg::WIDTH-1:0] reduced_modulus;
   logic [1:0]                status;

   modport source (output valid, output solution, output common_divisor,
                   output reduced_modulus, output status, input ready);
   modport sink   (input valid, input solution, input common_divisor,
                   input reduced_modulus, input status, output ready);
endinterface

@@ rtl/lcs_divider.sv @@
// ----------------------------------------------------------------------------
// lcs_divider: shared restoring divider
// One quotient bit per cycle; WIDTH or DW dividend bits over a WIDTH divisor.
// ----------------------------------------------------------------------------
module lcs_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  lcs_pkg::div_ctl_type      ctl,
   input  logic [lcs_pkg::DW-1:0]    dividend,
   input  logic [lcs_pkg::WIDTH-1:0] divisor,
   output lcs_pkg::div_sts_type      sts,
   output logic [lcs_pkg::WIDTH-1:0] quotient,
   output logic [lcs_pkg::WIDTH-1:0] remainder
);
   import lcs_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [DW-1:0]    dq_ff, dq_in;
   logic [WIDTH-1:0] den_ff, den_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;

   assign trial = {rem_ff, dq_ff[DW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      den_in  = den_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         den_in  = divisor;
         if (ctl.wide) begin
            dq_in  = dividend;
            cnt_in = CNT_W'(DW);
         end else begin
            dq_in  = {dividend[WIDTH-1:0], {WIDTH{1'b0}}};
            cnt_in = CNT_W'(WIDTH);
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         dq_in  = {dq_ff[DW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      den_ff <= den_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = dq_ff[WIDTH-1:0];
   assign remainder = rem_ff;

endmodule

@@ rtl/linear_congruence_solver.sv @@
// Steps: zero check, a mod n, then per Euclid step a divide, a multiply and an update;
//   then m = n / d, b / d, and the product (b/d) * inv with its reduction mod m. No solution
//   skips the product and its reduction; a zero modulus goes straight to the output.
// Throughput: one item at a time on the one shared restoring divider, one quotient bit per
//   cycle; next request transfers at the earliest in the cycle the response goes valid.
// ----------------------------------------------------------------------------
// linear_congruence_solver: solves a*x = b (mod n)
// Sequencer around a shared divider and one registered multiplier. The
// extended Euclid pass runs on (n, a) directly: its quotients match the
// pass on (n/d, a/d), so the same run yields both d and the inverse.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module linear_congruence_solver (
   input  logic       clock,
   input  logic       reset,
   lcs_req_if.sink    req_ch,
   lcs_rsp_if.source  rsp_ch
);
   import lcs_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_START   = 13'b0000000000010, // zero check, a mod n
      ST_MOD_A   = 13'b0000000000100,
      ST_EU_TEST = 13'b0000000001000, // loop test on r1
      ST_EU_DIV  = 13'b0000000010000, // q, r = r0 / r1
      ST_EU_MUL  = 13'b0000000100000, // q * t1
      ST_EU_UPD  = 13'b0000001000000, // t shift
      ST_RED_M   = 13'b0000010000000, // m = n / d
      ST_RED_B   = 13'b0000100000000, // b / d, divisibility
      ST_MUL_X   = 13'b0001000000000, // (b/d) * inv
      ST_X_GO    = 13'b0010000000000,
      ST_RED_X   = 13'b0100000000000, // product mod m
      ST_FINISH  = 13'b1000000000000  // hand to output register
   } state_type;

   state_type               state_ff, state_in;

   // operands
   logic [WIDTH-1:0]        a_ff, a_in;
   logic [WIDTH-1:0]        b_ff, b_in;
   logic [WIDTH-1:0]        n_ff, n_in;
   // Euclid state; t stays within +/- n, so WIDTH+1 signed bits
   logic [WIDTH-1:0]        r0_ff, r0_in;
   logic [WIDTH-1:0]        r1_ff, r1_in;
   logic signed [WIDTH:0]   t0_ff, t0_in;
   logic signed [WIDTH:0]   t1_ff, t1_in;
   logic [WIDTH-1:0]        q_ff, q_in;
   logic signed [DW+1:0]    prod_ff, prod_in;
   // results in flight
   logic [WIDTH-1:0]        d_ff, d_in;
   logic [WIDTH-1:0]        m_ff, m_in;
   logic [WIDTH-1:0]        bq_ff, bq_in;
   logic [WIDTH-1:0]        inv_ff, inv_in;
   logic [WIDTH-1:0]        sol_ff, sol_in;
   status_type              stat_ff, stat_in;

   // output register
   logic                    out_vld_ff, out_vld_in;
   logic [WIDTH-1:0]        out_sol_ff, out_sol_in;
   logic [WIDTH-1:0]        out_gcd_ff, out_gcd_in;
   logic [WIDTH-1:0]        out_mod_ff, out_mod_in;
   status_type              out_stat_ff, out_stat_in;

   // shared units
   div_ctl_type             div_ctl;
   div_sts_type             div_sts;
   logic [DW-1:0]           div_num;
   logic [WIDTH-1:0]        div_den;
   logic [WIDTH-1:0]        div_quo;
   logic [WIDTH-1:0]        div_rem;
   logic signed [WIDTH:0]   mul_a;
   logic signed [WIDTH:0]   mul_b;
   logic signed [DW+1:0]    mul_p;
   logic [WIDTH:0]          inv_sum;
   logic                    req_xfer;
   logic                    out_free;

   lcs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_num),
      .divisor   (div_den),
      .sts       (div_sts),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // one multiplier: Euclid q * t1, then the final (b/d) * inv
   always_comb begin
      if (state_ff == ST_MUL_X) begin
         mul_a = $signed({1'b0, bq_ff});
         mul_b = $signed({1'b0, inv_ff});
      end else begin
         mul_a = $signed({1'b0, q_ff});
         mul_b = t1_ff;
      end
   end
   assign mul_p = mul_a * mul_b;

   // inverse normalized into [0, m): add m once if negative, fold m to 0
   assign inv_sum = t0_ff[WIDTH] ? (t0_ff + $signed({1'b0, div_quo}))
                                 : t0_ff;

   assign req_xfer      = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign out_free      = !out_vld_ff || rsp_ch.ready;

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      n_in        = n_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      t0_in       = t0_ff;
      t1_in       = t1_ff;
      q_in        = q_ff;
      prod_in     = prod_ff;
      d_in        = d_ff;
      m_in        = m_ff;
      bq_in       = bq_ff;
      inv_in      = inv_ff;
      sol_in      = sol_ff;
      stat_in     = stat_ff;
      out_vld_in  = out_vld_ff && !rsp_ch.ready;
      out_sol_in  = out_sol_ff;
      out_gcd_in  = out_gcd_ff;
      out_mod_in  = out_mod_ff;
      out_stat_in = out_stat_ff;
      div_ctl     = '0;
      div_num     = '0;
      div_den     = n_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               a_in     = req_ch.coefficient;
               b_in     = req_ch.target;
               n_in     = req_ch.modulus;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (n_ff == '0) begin
               sol_in   = '0;
               d_in     = '0;
               m_in     = '0;
               stat_in  = STATUS_ZERO_MOD;
               state_in = ST_FINISH;
            end else begin
               div_ctl.start = 1'b1;
               div_num       = DW'(a_ff);
               div_den       = n_ff;
               state_in      = ST_MOD_A;
            end
         end
         ST_MOD_A: begin
            if (div_sts.done) begin
               r0_in    = n_ff;
               r1_in    = div_rem;
               t0_in    = '0;
               t1_in    = (WIDTH+1)'(1);
               state_in = ST_EU_TEST;
            end
         end
         ST_EU_TEST: begin
            div_ctl.start = 1'b1;
            if (r1_ff == '0) begin
               // r0 is the gcd; m = n / d next
               d_in     = r0_ff;
               div_num  = DW'(n_ff);
               div_den  = r0_ff;
               state_in = ST_RED_M;
            end else begin
               div_num  = DW'(r0_ff);
               div_den  = r1_ff;
               state_in = ST_EU_DIV;
            end
         end
         ST_EU_DIV: begin
            if (div_sts.done) begin
               q_in     = div_quo;
               r0_in    = r1_ff;
               r1_in    = div_rem;
               state_in = ST_EU_MUL;
            end
         end
         ST_EU_MUL: begin
            prod_in  = mul_p;
            state_in = ST_EU_UPD;
         end
         ST_EU_UPD: begin
            t0_in    = t1_ff;
            t1_in    = t0_ff - prod_ff[WIDTH:0];
            state_in = ST_EU_TEST;
         end
         ST_RED_M: begin
            if (div_sts.done) begin
               m_in          = div_quo;
               inv_in        = (inv_sum == {1'b0, div_quo}) ? '0 : inv_sum[WIDTH-1:0];
               div_ctl.start = 1'b1;
               div_num       = DW'(b_ff);
               div_den       = d_ff;
               state_in      = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (div_sts.done) begin
               bq_in = div_quo;
               if (div_rem != '0) begin
                  sol_in   = '0;
                  stat_in  = STATUS_NONE;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MUL_X;
               end
            end
         end
         ST_MUL_X: begin
            prod_in  = mul_p;
            state_in = ST_X_GO;
         end
         ST_X_GO: begin
            div_ctl.start = 1'b1;
            div_ctl.wide  = 1'b1;
            div_num       = prod_ff[DW-1:0];
            div_den       = m_ff;
            state_in      = ST_RED_X;
         end
         ST_RED_X: begin
            if (div_sts.done) begin
               sol_in   = div_rem;
               stat_in  = STATUS_SOLVED;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_sol_in  = sol_ff;
               out_gcd_in  = d_ff;
               out_mod_in  = m_ff;
               out_stat_in = stat_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      n_ff        <= n_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      q_ff        <= q_in;
      prod_ff     <= prod_in;
      d_ff        <= d_in;
      m_ff        <= m_in;
      bq_ff       <= bq_in;
      inv_ff      <= inv_in;
      sol_ff      <= sol_in;
      stat_ff     <= stat_in;
      out_sol_ff  <= out_sol_in;
      out_gcd_ff  <= out_gcd_in;
      out_mod_ff  <= out_mod_in;
      out_stat_ff <= out_stat_in;
   end

   assign rsp_ch.valid           = out_vld_ff;
   assign rsp_ch.solution        = out_sol_ff;
   assign rsp_ch.common_divisor  = out_gcd_ff;
   assign rsp_ch.reduced_modulus = out_mod_ff;
   assign rsp_ch.status          = out_stat_ff;

   // divider is never restarted mid-run and never fed a zero divisor
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy && (div_den != '0))
      else $error("divider start while busy or with zero divisor");

   // completion pulses only arrive while the sequencer waits on them
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_MOD_A) || (state_ff == ST_EU_DIV) ||
                       (state_ff == ST_RED_M) || (state_ff == ST_RED_B) ||
                       (state_ff == ST_RED_X))
      else $error("divider done outside a wait state");

   // a solved result is reduced below its modulus with a nonzero gcd
   a_solved_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STATUS_SOLVED)) |->
         (rsp_ch.solution < rsp_ch.reduced_modulus) && (rsp_ch.common_divisor != '0))
      else $error("solved result out of range");

   // an accepted request always enters the zero-modulus check next
   a_req_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_START))
      else $error("request transfer did not start the sequencer");

endmodule

@@ dv/linear_congruence_solver_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_congruence_solver_tb: self-checking bench for the congruence solver
// Sends coefficient/target/modulus triples over the request channel and checks
// every response against a behavioral solver: gcd, extended Euclid inverse and
// exact modular product. Both channels idle at random; a long response stall
// backs the block up, and two drain pauses let the block empty.
// ----------------------------------------------------------------------------
module linear_congruence_solver_tb;
   import lcs_pkg::*;

   localparam int W          = lcs_pkg::WIDTH;
   localparam int RAND_ITEMS = 650;
   localparam int IDLE_PCT   = 31;          // chance of an idle cycle per side
   localparam int HOLD_AT    = 120;         // response transfer that starts the stall
   localparam int HOLD_LEN   = 4000;        // cycles with rsp ready held low
   localparam int CALM_LO    = 300;         // stretch with no idling on either side
   localparam int CALM_HI    = 420;
   localparam int TAIL_WAIT  = 2000;        // worst-case item latency, with margin
   localparam int CYCLE_CAP  = 8000000;     // timeout

   typedef logic [W-1:0] word_type;

   // one pending request; drain_first holds it back until nothing is in flight
   typedef struct {
      word_type coefficient;
      word_type target;
      word_type modulus;
      bit       drain_first;
   } congruence_req_type;

   typedef struct {
      word_type   solution;
      word_type   common_divisor;
      word_type   reduced_modulus;
      status_type status;
   } congruence_rsp_type;

   logic clock;
   logic reset;

   lcs_req_if req_ch();
   lcs_rsp_if rsp_ch();

   linear_congruence_solver dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   congruence_req_type operand_q[$];    // requests not yet offered
   congruence_rsp_type solution_q[$];   // expected responses, oldest first

   int unsigned fail_count = 0;
   int unsigned req_sent   = 0;
   int unsigned rsp_seen   = 0;
   int unsigned n_solved   = 0;
   int unsigned n_unsolved = 0;
   int unsigned n_zero_mod = 0;
   int unsigned cycle_cnt  = 0;

   function automatic void queue_request(congruence_req_type r);
      operand_q.insert(operand_q.size(), r);
   endfunction

   function automatic void queue_expected(congruence_rsp_type r);
      solution_q.insert(solution_q.size(), r);
   endfunction

   // -------------------------------------------------------------------------
   // Behavioral solver
   // -------------------------------------------------------------------------
   function automatic word_type gcd_of(word_type p, word_type q);
      word_type r;
      while (q != 0) begin
         r = p % q;
         p = q;
         q = r;
      end
      return p;
   endfunction

   // inverse of a mod m, gcd(a, m) = 1, m >= 1; signed cofactors fit in 64 bits
   function automatic word_type inverse_of(word_type a, word_type m);
      longint r0, r1, t0, t1, qt, rn, tn;
      r0 = longint'(m);
      r1 = longint'(a % m);
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         qt = r0 / r1;
         rn = r0 - qt * r1;
         tn = t0 - qt * t1;
         r0 = r1;
         r1 = rn;
         t0 = t1;
         t1 = tn;
      end
      if (t0 < 0) t0 += longint'(m);
      return word_type'(longint'(t0) % longint'(m));
   endfunction

   function automatic congruence_rsp_type solve_congruence(word_type a, word_type b,
                                                           word_type n);
      congruence_rsp_type r;
      word_type           d, m, inv;
      logic [2*W-1:0]     prod;
      r.solution        = '0;
      r.common_divisor  = '0;
      r.reduced_modulus = '0;
      r.status          = STATUS_ZERO_MOD;
      if (n == 0) return r;
      d = gcd_of(a, n);
      m = n / d;
      r.common_divisor  = d;
      r.reduced_modulus = m;
      if (b % d != 0) begin
         r.status = STATUS_NONE;
         return r;
      end
      inv  = inverse_of(a / d, m);
      // full double-width product, reduced exactly
      prod = {{W{1'b0}}, (b / d) % m} * {{W{1'b0}}, inv};
      r.solution = word_type'(prod % {{W{1'b0}}, m});
      r.status   = STATUS_SOLVED;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Clock and timeout
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_CAP) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_cnt, solution_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request driver: offers the head of operand_q, records the expectation
   // at the transfer. Valid stays up until the transfer completes.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      congruence_req_type nxt;
      bit                 calm;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         calm = (req_sent >= CALM_LO) && (req_sent < CALM_HI);
         if (req_ch.valid && req_ch.ready) begin
            queue_expected(solve_congruence(req_ch.coefficient, req_ch.target,
                                            req_ch.modulus));
            req_sent <= req_sent + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            // a transfer at this edge counts as in flight, so a drain item is not offered behind it
            if (operand_q.size() > 0 &&
                !(operand_q[0].drain_first &&
                  (solution_q.size() > 0 || (req_ch.valid && req_ch.ready))) &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = operand_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.coefficient <= nxt.coefficient;
               req_ch.target      <= nxt.target;
               req_ch.modulus     <= nxt.modulus;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response ready: random idling, one long hold-off so the block fills and
   // stalls its input, and a calm stretch. Counts its own transfers.
   // -------------------------------------------------------------------------
   int unsigned hold_left = 0;
   int unsigned ready_xfers = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) ready_xfers <= ready_xfers + 1;
         if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && ready_xfers >= HOLD_AT) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_LEN;
            rsp_ch.ready <= 1'b0;
         end else if (ready_xfers >= CALM_LO && ready_xfers < CALM_HI) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: every response transfer against the oldest expectation
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      congruence_rsp_type exp_rsp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen <= rsp_seen + 1;
         if (solution_q.size() == 0) begin
            $display("%0t: unexpected response sol=%0h gcd=%0h m=%0h status=%0d",
                     $time, rsp_ch.solution, rsp_ch.common_divisor,
                     rsp_ch.reduced_modulus, rsp_ch.status);
            fail_count = fail_count + 1;
         end else begin
            exp_rsp = solution_q.pop_front();
            case (exp_rsp.status)
               STATUS_SOLVED: n_solved   <= n_solved + 1;
               STATUS_NONE:   n_unsolved <= n_unsolved + 1;
               default:       n_zero_mod <= n_zero_mod + 1;
            endcase
            if (rsp_ch.solution !== exp_rsp.solution) begin
               $display("%0t: solution mismatch: expected %0h, actual %0h",
                        $time, exp_rsp.solution, rsp_ch.solution);
               fail_count = fail_count + 1;
            end
            if (rsp_ch.common_divisor !== exp_rsp.common_divisor) begin
               $display("%0t: common_divisor mismatch: expected %0h, actual %0h",
                        $time, exp_rsp.common_divisor, rsp_ch.common_divisor);
               fail_count = fail_count + 1;
            end
            if (rsp_ch.reduced_modulus !== exp_rsp.reduced_modulus) begin
               $display("%0t: reduced_modulus mismatch: expected %0h, actual %0h",
                        $time, exp_rsp.reduced_modulus, rsp_ch.reduced_modulus);
               fail_count = fail_count + 1;
            end
            if (rsp_ch.status !== exp_rsp.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, exp_rsp.status, rsp_ch.status);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      congruence_req_type it;
      word_type           g, x;
      logic [2*W-1:0]     prod;
      int unsigned        kind;

      reset = 1'b1;

      // directed: corner cases first
      it.drain_first = 1'b0;
      it.coefficient = 5;             it.target = 3;             it.modulus = 0;
      queue_request(it);              // zero modulus
      it.coefficient = 0;             it.target = 0;             it.modulus = 0;
      queue_request(it);
      it.coefficient = 32'h12345678;  it.target = 32'hFFFFFFFF;  it.modulus = 0;
      queue_request(it);
      it.coefficient = 32'hFFFFFFFF;  it.target = 32'hFFFFFFFF;  it.modulus = 32'hFFFFFFFF;
      queue_request(it);
      it.coefficient = 4;             it.target = 3;             it.modulus = 6;
      queue_request(it);              // gcd does not divide target
      it.coefficient = 0;             it.target = 12;            it.modulus = 4;
      queue_request(it);              // zero coefficient, modulus divides target
      it.coefficient = 0;             it.target = 5;             it.modulus = 4;
      queue_request(it);              // zero coefficient, unsolvable
      it.coefficient = 0;             it.target = 32'hFFFFFFFF;  it.modulus = 32'hFFFFFFFF;
      queue_request(it);
      it.coefficient = 0;             it.target = 0;             it.modulus = 1;
      queue_request(it);
      it.coefficient = 7;             it.target = 5;             it.modulus = 1;
      queue_request(it);              // modulus one
      it.coefficient = 6;             it.target = 9;             it.modulus = 3;
      queue_request(it);              // reduced modulus one
      it.coefficient = 32'h80000000;  it.target = 32'h80000000;  it.modulus = 32'h80000000;
      queue_request(it);
      it.coefficient = 3;             it.target = 1;             it.modulus = 7;
      queue_request(it);
      it.coefficient = 14;            it.target = 30;            it.modulus = 100;
      queue_request(it);
      it.coefficient = 10;            it.target = 0;             it.modulus = 15;
      queue_request(it);
      // consecutive Fibonacci numbers: longest Euclid chain at this width
      it.coefficient = 32'd1836311903; it.target = 32'hFFFFFFFF; it.modulus = 32'd2971215073;
      queue_request(it);
      it.coefficient = 32'd2971215073; it.target = 1;            it.modulus = 32'd1836311903;
      queue_request(it);
      it.coefficient = 32'hFFFFFFFF;  it.target = 1;             it.modulus = 32'hFFFFFFFE;
      queue_request(it);
      it.coefficient = 32'hFFFFFFFE;  it.target = 1;             it.modulus = 32'hFFFFFFFF;
      queue_request(it);
      it.coefficient = 1;             it.target = 32'hFFFFFFFF;  it.modulus = 32'hFFFFFFFF;
      queue_request(it);
      it.coefficient = 32'hAAAAAAAA;  it.target = 32'h55555555;  it.modulus = 32'h55555555;
      queue_request(it);
      it.coefficient = 32'h55555555;  it.target = 32'hAAAAAAAA;  it.modulus = 32'hAAAAAAAA;
      queue_request(it);

      // random part; drain pauses at its start and halfway
      for (int i = 0; i < RAND_ITEMS; i++) begin
         it.drain_first = (i == 0) || (i == RAND_ITEMS / 2);
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // solvable by construction: target = a*x mod n
            it.modulus     = $urandom;
            if (it.modulus == 0) it.modulus = 1;
            it.coefficient = $urandom;
            x              = $urandom;
            prod           = {{W{1'b0}}, it.coefficient} * {{W{1'b0}}, x};
            it.target      = word_type'(prod % {{W{1'b0}}, it.modulus});
         end else if (kind < 60) begin
            // shared factor in all three, mostly solvable with gcd > 1
            g              = $urandom_range(1, 65535);
            it.modulus     = g * word_type'($urandom_range(1, 32'hFFFFFFFF / g));
            it.coefficient = g * word_type'($urandom_range(0, 32'hFFFFFFFF / g));
            it.target      = g * word_type'($urandom_range(0, 32'hFFFFFFFF / g));
         end else if (kind < 80) begin
            it.coefficient = $urandom;
            it.target      = $urandom;
            it.modulus     = $urandom;
         end else if (kind < 90) begin
            it.coefficient = $urandom_range(0, 255);
            it.target      = $urandom_range(0, 255);
            it.modulus     = $urandom_range(0, 255);
         end else begin
            it.coefficient = $urandom;
            it.target      = $urandom;
            case ($urandom_range(0, 4))
               0: it.modulus = 0;
               1: it.modulus = 1;
               2: it.modulus = 32'hFFFFFFFF;
               3: begin
                  it.modulus     = $urandom;
                  it.coefficient = 0;
               end
               default: begin
                  it.modulus     = $urandom;
                  it.coefficient = it.modulus;   // d = n, m = 1
               end
            endcase
         end
         queue_request(it);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (operand_q.size() > 0 || req_ch.valid || solution_q.size() > 0)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses: %0d solved, %0d unsolvable,",
               req_sent, rsp_seen, n_solved, n_unsolved);
      $display("%0d zero modulus; random idling, one long response stall, drain pauses",
               n_zero_mod);
      if (fail_count == 0 && solution_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (solution_q.size() > 0)
            $display("%0t: %0d expected responses never arrived", $time, solution_q.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
